FILE: hdl/flss_pkg.sv
// ============================================================================
// Floppy logic state sequencer package
// Shared types, codes, item layouts and the sequencer PROM contents.
// ============================================================================
`default_nettype none

package flss_pkg;

    // Item layouts on the stream ports.
    localparam int IN_DATA_W  = 16;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 48;
    localparam int OUT_USER_W = 1;

    typedef logic [1:0] t_action;
    localparam t_action ACT_TICK  = 2'd0;
    localparam t_action ACT_READ  = 2'd1;
    localparam t_action ACT_WRITE = 2'd2;

    typedef logic [3:0] t_switch;
    localparam t_switch SW_MOTOR_OFF = 4'd8;
    localparam t_switch SW_MOTOR_ON  = 4'd9;
    localparam t_switch SW_Q6_LOW    = 4'd12;
    localparam t_switch SW_Q6_HIGH   = 4'd13;
    localparam t_switch SW_Q7_LOW    = 4'd14;
    localparam t_switch SW_Q7_HIGH   = 4'd15;

    typedef logic [3:0] t_seq_op;
    localparam t_seq_op OP_CLEAR     = 4'h0;
    localparam t_seq_op OP_SHIFT_L0  = 4'h9;
    localparam t_seq_op OP_SHIFT_R   = 4'hA;
    localparam t_seq_op OP_LOAD      = 4'hB;
    localparam t_seq_op OP_SHIFT_L1  = 4'hD;

    localparam logic [7:0] DATA_IDLE    = 8'hFF;
    localparam logic [7:0] PROTECT_FLAG = 8'h80;
    localparam logic [7:0] LATCH_RESET  = 8'hFF;

    localparam logic [7:0] SEQ_ROM [0:255] = '{
        8'h18,8'h18,8'h18,8'h18,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,8'h18,
        8'h2D,8'h2D,8'h38,8'h38,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,8'h28,
        8'hD8,8'h38,8'h08,8'h28,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h39,8'h39,8'h39,8'h39,8'h3B,8'h3B,8'h3B,8'h3B,
        8'hD8,8'h48,8'h48,8'h48,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,8'h48,
        8'hD8,8'h58,8'hD8,8'h58,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,8'h58,
        8'hD8,8'h68,8'hD8,8'h68,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,8'h68,
        8'hD8,8'h78,8'hD8,8'h78,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,8'h78,
        8'hD8,8'h88,8'hD8,8'h88,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h08,8'h08,8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,
        8'hD8,8'h98,8'hD8,8'h98,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,8'h98,
        8'hD8,8'h29,8'hD8,8'hA8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,8'hA8,
        8'hCD,8'hBD,8'hD8,8'hB8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hB9,8'hB9,8'hB9,8'hB9,8'hBB,8'hBB,8'hBB,8'hBB,
        8'hD9,8'h59,8'hD8,8'hC8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,8'hC8,
        8'hD9,8'hD9,8'hD8,8'hA0,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,8'hD8,
        8'hD8,8'h08,8'hE8,8'hE8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,8'hE8,
        8'hFD,8'hFD,8'hF8,8'hF8,8'h0A,8'h0A,8'h0A,8'h0A,
        8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,8'hF8,
        8'hDD,8'h4D,8'hE0,8'hE0,8'h0A,8'h0A,8'h0A,8'h0A,
        8'h88,8'h88,8'h08,8'h08,8'h88,8'h88,8'h08,8'h08
    };

endpackage

`default_nettype wire

FILE: hdl/floppy_logic_state_sequencer_top.sv
// ============================================================================
// Floppy logic state sequencer
// Controller card core: PROM sequencer, data shifter, nibble writer, stepper.
// ============================================================================
// Usage:
// Each input item on the s_axis channel is a sequencer tick, a soft switch
// read or a soft switch write, selected by tuser. Every item produces exactly
// one result item on the m_axis channel with the read byte, the head
// position, the cell advance strobe, the surface write bit, an optional
// written nibble and the motor state. The write-back enable register is set
// through the cfg channel, which is always ready; the user must write it only
// while idle, as the block itself does not enforce this. An accepted item is
// held in an input register, and the sequencer step and the state update
// happen when it leaves that register, which also loads the result register.
// One item is taken in every cycle while the receiver does not stall, the
// step being a single PROM lookup and register update. When the receiver
// stalls, the result is held and the input register fills, after which
// s_axis_tready drops until the result is taken. Reset clears all state, sets
// the CPU latch to all ones and empties both registers.
`default_nettype none

module floppy_logic_state_sequencer_top #(
    parameter int NIBBLES_PER_TRACK = 6656,
    parameter int TRACK_COUNT       = 35
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           s_axis_tvalid,
    output logic                                s_axis_tready,
    // tdata: switch_addr[3:0], write_value[11:4], disk_present[12],
    // disk_bit[13], write_protected[14], zero[15].
    input  wire logic [flss_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // tuser: action[1:0].
    input  wire logic [flss_pkg::IN_USER_W-1:0] s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  wire logic                           m_axis_tready,
    // tdata: read_data[7:0], head_position[15:8], bit_advance[16],
    // write_data_bit[17], nibble_value[25:18], nibble_track[31:26],
    // nibble_position[44:32], motor_running[45], zero[47:46].
    output logic [flss_pkg::OUT_DATA_W-1:0]     m_axis_tdata,
    // tuser: nibble_write_valid[0].
    output logic [flss_pkg::OUT_USER_W-1:0]     m_axis_tuser,
    input  wire logic                           i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire logic                           i_cfg_data
);
    import flss_pkg::*;

    localparam int QT_RAW   = (TRACK_COUNT - 1) * 4;
    localparam int QT_LIMIT = (QT_RAW > 255) ? 255 : QT_RAW;
    localparam logic [8:0]  QT_LIMIT_W = 9'(QT_LIMIT);
    localparam logic [13:0] SLOT_WRAP  = 14'(NIBBLES_PER_TRACK);

    logic                  r_in_valid;
    logic [IN_DATA_W-1:0]  r_in_data;
    t_action               r_in_action;
    logic                  r_out_valid;
    logic [OUT_DATA_W-1:0] r_out_data;
    logic [OUT_USER_W-1:0] r_out_user;
    logic                  r_wb_en;

    logic [3:0]  r_seq, n_seq;
    logic [7:0]  r_shift, n_shift;
    logic [2:0]  r_cell, n_cell;
    logic [7:0]  r_wasm, n_wasm;
    logic [2:0]  r_wcnt, n_wcnt;
    logic [7:0]  r_latch, n_latch;
    logic [12:0] r_slot, n_slot;
    logic [7:0]  r_hq, n_hq;
    logic [3:0]  r_phase, n_phase;
    logic        r_motor, n_motor;
    logic        r_load, n_load;
    logic        r_write, n_write;

    logic                  fire;
    logic                  out_free;
    logic [OUT_DATA_W-1:0] n_out_data;
    logic [OUT_USER_W-1:0] n_out_user;

    assign out_free      = !r_out_valid || m_axis_tready;
    assign fire          = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_user;
    assign o_cfg_ready   = 1'b1;

    always_comb begin
        t_switch     sw;
        logic [7:0]  wval;
        logic        present;
        logic        dbit;
        logic        wp;
        logic [7:0]  rd;
        logic        do_tick;
        logic        rd_shift;
        logic        access;
        logic [3:0]  pbit;
        logic [1:0]  cur;
        logic        fwd;
        logic        back;
        logic [8:0]  up;
        logic        pulse;
        logic [7:0]  op;
        logic        adv;
        logic        nv;
        logic [7:0]  nval;
        logic [5:0]  ntrk;
        logic [12:0] npos;
        logic [13:0] slot_inc;

        sw      = t_switch'(r_in_data[3:0]);
        wval    = r_in_data[11:4];
        present = r_in_data[12];
        dbit    = r_in_data[13];
        wp      = r_in_data[14];

        n_seq   = r_seq;
        n_shift = r_shift;
        n_cell  = r_cell;
        n_wasm  = r_wasm;
        n_wcnt  = r_wcnt;
        n_latch = r_latch;
        n_slot  = r_slot;
        n_hq    = r_hq;
        n_phase = r_phase;
        n_motor = r_motor;
        n_load  = r_load;
        n_write = r_write;

        rd       = '0;
        do_tick  = 1'b0;
        rd_shift = 1'b0;
        adv      = 1'b0;
        nv       = 1'b0;
        nval     = '0;
        ntrk     = '0;
        npos     = '0;
        pbit     = 4'b0001 << sw[2:1];
        cur      = '0;
        fwd      = 1'b0;
        back     = 1'b0;
        up       = '0;
        pulse    = 1'b0;
        op       = '0;
        slot_inc = '0;

        access = (r_in_action == ACT_READ) || (r_in_action == ACT_WRITE);

        if (access) begin
            if (!sw[3]) begin
                if (sw[0]) begin
                    n_phase = r_phase | pbit;
                    if ((r_phase & pbit) == 4'd0) begin
                        cur  = r_hq[2:1];
                        fwd  = n_phase[2'(cur + 2'd1)];
                        back = n_phase[2'(cur + 2'd3)];
                        up   = {1'b0, r_hq} + 9'd2;
                        if (fwd && !back) begin
                            n_hq = (up > QT_LIMIT_W) ? QT_LIMIT_W[7:0] : up[7:0];
                        end else if (back && !fwd) begin
                            n_hq = (r_hq < 8'd2) ? 8'd0 : r_hq - 8'd2;
                        end
                    end
                end else begin
                    n_phase = r_phase & ~pbit;
                end
            end else begin
                case (sw)
                    SW_MOTOR_OFF: n_motor = 1'b0;
                    SW_MOTOR_ON:  n_motor = 1'b1;
                    SW_Q6_LOW:    n_load  = 1'b0;
                    SW_Q6_HIGH:   n_load  = 1'b1;
                    SW_Q7_LOW:    n_write = 1'b0;
                    SW_Q7_HIGH:   n_write = 1'b1;
                    default:      ;
                endcase
            end
        end

        case (r_in_action)
            ACT_TICK: begin
                do_tick = r_motor && present;
            end
            ACT_READ: begin
                if (sw == SW_Q6_LOW && !n_write && !n_load) begin
                    if (!present || !n_motor) begin
                        rd = DATA_IDLE;
                    end else begin
                        do_tick  = 1'b1;
                        rd_shift = 1'b1;
                    end
                end else if (sw == SW_Q6_HIGH && !n_write) begin
                    rd = (present && wp) ? PROTECT_FLAG : 8'd0;
                end
            end
            ACT_WRITE: begin
                if (n_write && sw == SW_Q6_HIGH) begin
                    n_latch = wval;
                end
            end
            default: ;
        endcase

        if (do_tick) begin
            pulse = (r_cell == 3'd4) && dbit;
            op    = SEQ_ROM[{r_seq, n_write, n_load, r_shift[7], !pulse}];
            case (t_seq_op'(op[3:0]))
                OP_CLEAR:    n_shift = '0;
                OP_SHIFT_L0: n_shift = {r_shift[6:0], 1'b0};
                OP_SHIFT_R:  n_shift = {wp, r_shift[7:1]};
                OP_LOAD:     n_shift = n_latch;
                OP_SHIFT_L1: n_shift = {r_shift[6:0], 1'b1};
                default:     ;
            endcase
            n_seq  = op[7:4];
            n_cell = r_cell + 3'd1;
            if (r_cell == 3'd7) begin
                adv = 1'b1;
                if (n_write) begin
                    n_wasm = {r_wasm[6:0], n_seq[3]};
                    n_wcnt = r_wcnt + 3'd1;
                    if (r_wcnt == 3'd7) begin
                        if (r_wb_en) begin
                            nv   = 1'b1;
                            nval = n_wasm;
                            ntrk = n_hq[7:2];
                            npos = r_slot;
                        end
                        slot_inc = {1'b0, r_slot} + 14'd1;
                        n_slot   = (slot_inc >= SLOT_WRAP) ? 13'd0 : slot_inc[12:0];
                    end
                end
            end
        end

        if (rd_shift) begin
            rd = n_shift;
        end

        n_out_data = {2'b00, n_motor, npos, ntrk, nval, n_seq[3], adv, n_hq, rd};
        n_out_user = nv;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_wb_en     <= 1'b0;
            r_seq       <= '0;
            r_shift     <= '0;
            r_cell      <= '0;
            r_wasm      <= '0;
            r_wcnt      <= '0;
            r_latch     <= LATCH_RESET;
            r_slot      <= '0;
            r_hq        <= '0;
            r_phase     <= '0;
            r_motor     <= 1'b0;
            r_load      <= 1'b0;
            r_write     <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                r_wb_en <= i_cfg_data;
            end
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (fire) begin
                r_seq   <= n_seq;
                r_shift <= n_shift;
                r_cell  <= n_cell;
                r_wasm  <= n_wasm;
                r_wcnt  <= n_wcnt;
                r_latch <= n_latch;
                r_slot  <= n_slot;
                r_hq    <= n_hq;
                r_phase <= n_phase;
                r_motor <= n_motor;
                r_load  <= n_load;
                r_write <= n_write;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_data   <= s_axis_tdata;
            r_in_action <= t_action'(s_axis_tuser);
        end
        if (fire) begin
            r_out_data <= n_out_data;
            r_out_user <= n_out_user;
        end
    end

endmodule

`default_nettype wire

FILE: hdl/flss_checker.sv
// ============================================================================
// Floppy logic state sequencer port checker
// Port-level checks over time, bound to the top level.
// ============================================================================
`default_nettype none

module flss_checker #(
    parameter int TRACK_COUNT = 35
) (
    input wire logic                            i_clk,
    input wire logic                            i_rst_n,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [flss_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input wire logic [flss_pkg::OUT_USER_W-1:0] m_axis_tuser
);
    import flss_pkg::*;

    localparam int QT_RAW   = (TRACK_COUNT - 1) * 4;
    localparam int QT_LIMIT = (QT_RAW > 255) ? 255 : QT_RAW;
    localparam logic [7:0] QT_LIMIT_W = 8'(QT_LIMIT);

    a_reset_empty: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser))
        else $error("stalled result changed");

    a_nibble_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[44:18] == 27'd0)
        else $error("nibble fields set without a nibble");

    a_nibble_cell: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[16])
        else $error("nibble emitted outside a cell boundary");

    a_head_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:8] <= QT_LIMIT_W)
        else $error("head position beyond last track");

endmodule

bind floppy_logic_state_sequencer_top flss_checker #(
    .TRACK_COUNT(TRACK_COUNT)
) u_flss_checker (.*);

`default_nettype wire
